// ===== sv/jump_squat_gesture_detector_assert.svh =====
// assertion macros for the jump/squat gesture detector
// both macros sample on the rising edge of i_clk and are off during reset
`ifndef JUMP_SQUAT_GESTURE_DETECTOR_ASSERT_SVH
`define JUMP_SQUAT_GESTURE_DETECTOR_ASSERT_SVH

// same-cycle implication
`define JSGD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define JSGD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/jsgd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsgd_pkg
// Shared codes, register map, reset values and types of the gesture detector.
// ----------------------------------------------------------------------------
package jsgd_pkg;

    localparam int unsigned ZW = 16;
    localparam int unsigned TW = 32;
    localparam int unsigned SW = 3;
    localparam int unsigned EW = 3;
    localparam int unsigned AW = 5;
    localparam int unsigned DW = 32;

    // gesture states
    localparam logic [SW-1:0] ST_IDLE       = 3'd0;
    localparam logic [SW-1:0] ST_JUMP_UP    = 3'd1;
    localparam logic [SW-1:0] ST_JUMP_DOWN  = 3'd2;
    localparam logic [SW-1:0] ST_SQUAT_DOWN = 3'd3;
    localparam logic [SW-1:0] ST_SQUAT_UP   = 3'd4;

    // event codes
    localparam logic [EW-1:0] EV_NONE        = 3'd0;
    localparam logic [EW-1:0] EV_JUMP_BEGIN  = 3'd1;
    localparam logic [EW-1:0] EV_SQUAT_BEGIN = 3'd2;
    localparam logic [EW-1:0] EV_JUMP_END    = 3'd3;
    localparam logic [EW-1:0] EV_SQUAT_END   = 3'd4;
    localparam logic [EW-1:0] EV_TIMEOUT     = 3'd5;

    // register indexes
    localparam logic [2:0] REG_JUMP_START  = 3'd0;
    localparam logic [2:0] REG_SQUAT_START = 3'd1;
    localparam logic [2:0] REG_JUMP_FALL   = 3'd2;
    localparam logic [2:0] REG_SQUAT_RISE  = 3'd3;
    localparam logic [2:0] REG_JUMP_LAND   = 3'd4;
    localparam logic [2:0] REG_SQUAT_END   = 3'd5;
    localparam logic [2:0] REG_COOLDOWN    = 3'd6;
    localparam logic [2:0] REG_ACTION_TIME = 3'd7;

    // reset values
    localparam logic [ZW-1:0] RST_JUMP_START  = 16'd32000;
    localparam logic [ZW-1:0] RST_SQUAT_START = 16'd5000;
    localparam logic [ZW-1:0] RST_JUMP_FALL   = 16'd22000;
    localparam logic [ZW-1:0] RST_SQUAT_RISE  = 16'd16000;
    localparam logic [ZW-1:0] RST_JUMP_LAND   = 16'd18000;
    localparam logic [ZW-1:0] RST_SQUAT_END   = 16'd25000;
    localparam logic [ZW-1:0] RST_COOLDOWN    = 16'd700;
    localparam logic [ZW-1:0] RST_ACTION_TIME = 16'd500;

    typedef struct packed {
        logic signed [ZW-1:0] jump_start_level;
        logic signed [ZW-1:0] squat_start_level;
        logic signed [ZW-1:0] jump_fall_level;
        logic signed [ZW-1:0] squat_rise_level;
        logic signed [ZW-1:0] jump_land_level;
        logic signed [ZW-1:0] squat_end_level;
        logic [ZW-1:0]        cooldown_ms;
        logic [ZW-1:0]        action_time_ms;
    } t_cfg;

    typedef struct packed {
        logic [SW-1:0] gesture_state;
        logic [TW-1:0] start_time;
        logic [TW-1:0] finish_time;
    } t_gstate;

    typedef struct packed {
        t_gstate       nxt;
        logic [EW-1:0] event_code;
    } t_step;

endpackage

// ===== sv/jsgd_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsgd_cfg_regs
// APB-style register file holding the six levels, cooldown and action time.
// ----------------------------------------------------------------------------
module jsgd_cfg_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [jsgd_pkg::AW-1:0]    paddr,
    input  wire logic [jsgd_pkg::DW-1:0]    pwdata,
    output logic      [jsgd_pkg::DW-1:0]    prdata,
    output logic                            pready,
    output jsgd_pkg::t_cfg                  o_cfg
);

    jsgd_pkg::t_cfg  r_cfg;
    logic [2:0]      w_idx;
    logic            w_wr;
    logic [15:0]     w_wd;

    assign w_idx  = paddr[4:2];
    assign w_wr   = psel & penable & pwrite;
    assign w_wd   = pwdata[15:0];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.jump_start_level  <= jsgd_pkg::RST_JUMP_START;
            r_cfg.squat_start_level <= jsgd_pkg::RST_SQUAT_START;
            r_cfg.jump_fall_level   <= jsgd_pkg::RST_JUMP_FALL;
            r_cfg.squat_rise_level  <= jsgd_pkg::RST_SQUAT_RISE;
            r_cfg.jump_land_level   <= jsgd_pkg::RST_JUMP_LAND;
            r_cfg.squat_end_level   <= jsgd_pkg::RST_SQUAT_END;
            r_cfg.cooldown_ms       <= jsgd_pkg::RST_COOLDOWN;
            r_cfg.action_time_ms    <= jsgd_pkg::RST_ACTION_TIME;
        end else if (w_wr) begin
            unique case (w_idx)
                jsgd_pkg::REG_JUMP_START:  r_cfg.jump_start_level  <= w_wd;
                jsgd_pkg::REG_SQUAT_START: r_cfg.squat_start_level <= w_wd;
                jsgd_pkg::REG_JUMP_FALL:   r_cfg.jump_fall_level   <= w_wd;
                jsgd_pkg::REG_SQUAT_RISE:  r_cfg.squat_rise_level  <= w_wd;
                jsgd_pkg::REG_JUMP_LAND:   r_cfg.jump_land_level   <= w_wd;
                jsgd_pkg::REG_SQUAT_END:   r_cfg.squat_end_level   <= w_wd;
                jsgd_pkg::REG_COOLDOWN:    r_cfg.cooldown_ms       <= w_wd;
                jsgd_pkg::REG_ACTION_TIME: r_cfg.action_time_ms    <= w_wd;
                default: ;
            endcase
        end
    end

    // levels read back sign extended, times zero extended
    always_comb begin
        unique case (w_idx)
            jsgd_pkg::REG_JUMP_START:
                prdata = {{16{r_cfg.jump_start_level[15]}}, r_cfg.jump_start_level};
            jsgd_pkg::REG_SQUAT_START:
                prdata = {{16{r_cfg.squat_start_level[15]}}, r_cfg.squat_start_level};
            jsgd_pkg::REG_JUMP_FALL:
                prdata = {{16{r_cfg.jump_fall_level[15]}}, r_cfg.jump_fall_level};
            jsgd_pkg::REG_SQUAT_RISE:
                prdata = {{16{r_cfg.squat_rise_level[15]}}, r_cfg.squat_rise_level};
            jsgd_pkg::REG_JUMP_LAND:
                prdata = {{16{r_cfg.jump_land_level[15]}}, r_cfg.jump_land_level};
            jsgd_pkg::REG_SQUAT_END:
                prdata = {{16{r_cfg.squat_end_level[15]}}, r_cfg.squat_end_level};
            jsgd_pkg::REG_COOLDOWN:
                prdata = {16'd0, r_cfg.cooldown_ms};
            jsgd_pkg::REG_ACTION_TIME:
                prdata = {16'd0, r_cfg.action_time_ms};
            default:
                prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/jsgd_step_logic.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsgd_step_logic
// Combinational next-state logic: the ordered, cascading transition checks
// for one sample, giving the new gesture state, timestamps and event code.
// ----------------------------------------------------------------------------
module jsgd_step_logic (
    input  wire jsgd_pkg::t_cfg              i_cfg,
    input  wire jsgd_pkg::t_gstate           i_cur,
    input  wire logic signed [jsgd_pkg::ZW-1:0] i_accel_z,
    input  wire logic [jsgd_pkg::TW-1:0]     i_now_ms,
    output jsgd_pkg::t_step                  o_step
);

    logic [jsgd_pkg::SW-1:0] v_st;
    logic [jsgd_pkg::TW-1:0] v_start;
    logic [jsgd_pkg::TW-1:0] v_finish;
    logic [jsgd_pkg::EW-1:0] v_ev;
    logic [jsgd_pkg::TW-1:0] w_since_finish;
    logic [jsgd_pkg::TW-1:0] w_timeout;
    logic                    w_cool_ok;
    logic                    w_elapsed;

    assign w_since_finish = i_now_ms - i_cur.finish_time;
    assign w_cool_ok      = w_since_finish > {16'd0, i_cfg.cooldown_ms};
    assign w_timeout      = {15'd0, i_cfg.action_time_ms, 1'b0};
    // elapsed is taken from the stored start time; a start this sample is kept from timing out by its event code
    assign w_elapsed      = (i_now_ms - i_cur.start_time) > w_timeout;

    always_comb begin
        v_st     = i_cur.gesture_state;
        v_start  = i_cur.start_time;
        v_finish = i_cur.finish_time;
        v_ev     = jsgd_pkg::EV_NONE;

        if (v_st == jsgd_pkg::ST_IDLE && w_cool_ok
            && $signed(i_accel_z) > $signed(i_cfg.jump_start_level)) begin
            v_st    = jsgd_pkg::ST_JUMP_UP;
            v_start = i_now_ms;
            v_ev    = jsgd_pkg::EV_JUMP_BEGIN;
        end
        if (v_st == jsgd_pkg::ST_IDLE && w_cool_ok
            && $signed(i_accel_z) < $signed(i_cfg.squat_start_level)) begin
            v_st    = jsgd_pkg::ST_SQUAT_DOWN;
            v_start = i_now_ms;
            v_ev    = jsgd_pkg::EV_SQUAT_BEGIN;
        end
        if (v_st == jsgd_pkg::ST_JUMP_UP
            && $signed(i_accel_z) < $signed(i_cfg.jump_fall_level)) begin
            v_st = jsgd_pkg::ST_JUMP_DOWN;
        end
        if (v_st == jsgd_pkg::ST_SQUAT_DOWN
            && $signed(i_accel_z) > $signed(i_cfg.squat_rise_level)) begin
            v_st = jsgd_pkg::ST_SQUAT_UP;
        end
        if (v_st == jsgd_pkg::ST_JUMP_DOWN
            && $signed(i_accel_z) < $signed(i_cfg.jump_land_level)) begin
            v_st     = jsgd_pkg::ST_IDLE;
            v_finish = i_now_ms;
            v_ev     = jsgd_pkg::EV_JUMP_END;
        end
        if (v_st == jsgd_pkg::ST_SQUAT_UP
            && $signed(i_accel_z) > $signed(i_cfg.squat_end_level)) begin
            v_st     = jsgd_pkg::ST_IDLE;
            v_finish = i_now_ms;
            v_ev     = jsgd_pkg::EV_SQUAT_END;
        end
        if (v_st != jsgd_pkg::ST_IDLE && v_ev != jsgd_pkg::EV_JUMP_BEGIN
            && v_ev != jsgd_pkg::EV_SQUAT_BEGIN && w_elapsed) begin
            v_st     = jsgd_pkg::ST_IDLE;
            v_finish = i_now_ms;
            v_start  = i_now_ms;
            v_ev     = jsgd_pkg::EV_TIMEOUT;
        end

        o_step.nxt.gesture_state = v_st;
        o_step.nxt.start_time    = v_start;
        o_step.nxt.finish_time   = v_finish;
        o_step.event_code        = v_ev;
    end

endmodule
`default_nettype wire

// ===== sv/jump_squat_gesture_detector.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jump_squat_gesture_detector
// Jump/squat gesture machine over a stream of vertical acceleration samples.
//
//   channel | valid      | stall       | payload
//   --------+------------+-------------+------------------------------------
//   in      | i_in_valid | o_in_stall  | i_accel_z, i_now_ms
//   out     | o_out_valid| i_out_stall | o_motion_state, o_event_code
//   cfg     | psel/pen.  | pready = 1  | paddr, pwdata, prdata
//
// one word per cycle sustained while i_out_stall is low; a word passes the input register,
// then the result register, with the state updated through the step logic
// synchronous active-low reset restores register defaults and the idle state
// a stalled result holds; the input register still fills behind it, and
// o_in_stall rises only when both registers hold a word
// ----------------------------------------------------------------------------
`include "jump_squat_gesture_detector_assert.svh"
module jump_squat_gesture_detector (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic signed [jsgd_pkg::ZW-1:0] i_accel_z,
    input  wire logic [jsgd_pkg::TW-1:0]        i_now_ms,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [jsgd_pkg::SW-1:0]             o_motion_state,
    output logic [jsgd_pkg::EW-1:0]             o_event_code,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [jsgd_pkg::AW-1:0]        paddr,
    input  wire logic [jsgd_pkg::DW-1:0]        pwdata,
    output logic      [jsgd_pkg::DW-1:0]        prdata,
    output logic                                pready
);

    jsgd_pkg::t_cfg     w_cfg;
    jsgd_pkg::t_gstate  r_gst;
    jsgd_pkg::t_step    w_step;

    logic                           r_in_vld;
    logic signed [jsgd_pkg::ZW-1:0] r_accel_z;
    logic [jsgd_pkg::TW-1:0]        r_now_ms;
    logic                           r_out_vld;
    logic [jsgd_pkg::SW-1:0]        r_motion_state;
    logic [jsgd_pkg::EW-1:0]        r_event_code;
    logic                           w_out_hold;
    logic                           w_adv;

    jsgd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    jsgd_step_logic u_step (
        .i_cfg     (w_cfg),
        .i_cur     (r_gst),
        .i_accel_z (r_accel_z),
        .i_now_ms  (r_now_ms),
        .o_step    (w_step)
    );

    assign w_out_hold = r_out_vld & i_out_stall;
    assign w_adv      = r_in_vld & ~w_out_hold;
    assign o_in_stall = r_in_vld & w_out_hold;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_accel_z <= i_accel_z;
            r_now_ms  <= i_now_ms;
        end
    end

    // gesture state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gst.gesture_state <= jsgd_pkg::ST_IDLE;
            r_gst.start_time    <= '0;
            r_gst.finish_time   <= '0;
        end else if (w_adv) begin
            r_gst <= w_step.nxt;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_motion_state <= w_step.nxt.gesture_state;
            r_event_code   <= w_step.event_code;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_motion_state = r_motion_state;
    assign o_event_code   = r_event_code;

    `JSGD_ASSERT_SAME(a_end_is_idle,
        r_out_vld && (r_event_code == jsgd_pkg::EV_JUMP_END
            || r_event_code == jsgd_pkg::EV_SQUAT_END
            || r_event_code == jsgd_pkg::EV_TIMEOUT),
        r_motion_state == jsgd_pkg::ST_IDLE,
        "gesture end word not in idle state")
    `JSGD_ASSERT_SAME(a_jump_begin_state,
        r_out_vld && r_event_code == jsgd_pkg::EV_JUMP_BEGIN,
        r_motion_state == jsgd_pkg::ST_JUMP_UP
            || r_motion_state == jsgd_pkg::ST_JUMP_DOWN,
        "jump begin word outside jump states")
    `JSGD_ASSERT_SAME(a_stall_needs_word, o_in_stall, r_in_vld && r_out_vld,
        "input stalled with a free register")
    `JSGD_ASSERT_NEXT(a_adv_fills_out, w_adv, r_out_vld,
        "advanced word missing from result register")

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the jump/squat gesture detector.
// A scoreboard object keeps its own thresholds, cooldown, action time and
// gesture state, works out the state and event code of every accepted sample
// and checks the result words in order. Directed samples step through the
// cooldown, the timeout, timestamp wrap, out-of-order time and gestures that
// run through several transitions on one sample. Random gestures and noise
// then run under several register settings, extremes included, with random
// input gaps, random output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
    import jsgd_pkg::*;

    typedef struct packed {
        logic [SW-1:0] motion;
        logic [EW-1:0] code;
    } t_motion_word;

    class gesture_scoreboard;
        logic signed [ZW-1:0] jump_start, squat_start, jump_fall;
        logic signed [ZW-1:0] squat_rise, jump_land, squat_end;
        logic [ZW-1:0]        cooldown, action_time;
        logic [SW-1:0]        gesture;
        logic [TW-1:0]        t_start, t_finish;
        t_motion_word         awaited[$];
        int                   n_samples, n_checked, n_bad;
        int                   n_event[8];

        function new();
            jump_start  = RST_JUMP_START;
            squat_start = RST_SQUAT_START;
            jump_fall   = RST_JUMP_FALL;
            squat_rise  = RST_SQUAT_RISE;
            jump_land   = RST_JUMP_LAND;
            squat_end   = RST_SQUAT_END;
            cooldown    = RST_COOLDOWN;
            action_time = RST_ACTION_TIME;
            gesture     = ST_IDLE;
            t_start     = '0;
            t_finish    = '0;
            n_samples   = 0;
            n_checked   = 0;
            n_bad       = 0;
            foreach (n_event[i]) n_event[i] = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [ZW-1:0] val);
            case (idx)
                REG_JUMP_START:  jump_start  = val;
                REG_SQUAT_START: squat_start = val;
                REG_JUMP_FALL:   jump_fall   = val;
                REG_SQUAT_RISE:  squat_rise  = val;
                REG_JUMP_LAND:   jump_land   = val;
                REG_SQUAT_END:   squat_end   = val;
                REG_COOLDOWN:    cooldown    = val;
                REG_ACTION_TIME: action_time = val;
                default: ;
            endcase
        endfunction

        // one accepted sample: advance the gesture machine, queue its word
        function void note_sample(logic signed [ZW-1:0] z, logic [TW-1:0] now);
            logic [EW-1:0] ev;
            logic [TW-1:0] limit;
            ev    = EV_NONE;
            limit = {15'd0, action_time, 1'b0};
            if (gesture == ST_IDLE && (now - t_finish) > cooldown && z > jump_start) begin
                gesture = ST_JUMP_UP;
                t_start = now;
                ev      = EV_JUMP_BEGIN;
            end
            if (gesture == ST_IDLE && (now - t_finish) > cooldown && z < squat_start) begin
                gesture = ST_SQUAT_DOWN;
                t_start = now;
                ev      = EV_SQUAT_BEGIN;
            end
            if (gesture == ST_JUMP_UP && z < jump_fall)
                gesture = ST_JUMP_DOWN;
            if (gesture == ST_SQUAT_DOWN && z > squat_rise)
                gesture = ST_SQUAT_UP;
            if (gesture == ST_JUMP_DOWN && z < jump_land) begin
                gesture  = ST_IDLE;
                t_finish = now;
                ev       = EV_JUMP_END;
            end
            if (gesture == ST_SQUAT_UP && z > squat_end) begin
                gesture  = ST_IDLE;
                t_finish = now;
                ev       = EV_SQUAT_END;
            end
            if (gesture != ST_IDLE && (now - t_start) > limit) begin
                gesture  = ST_IDLE;
                t_finish = now;
                t_start  = now;
                ev       = EV_TIMEOUT;
            end
            awaited.push_back('{gesture, ev});
            n_event[ev]++;
            n_samples++;
        endfunction

        function void check_result(logic [SW-1:0] motion, logic [EW-1:0] code);
            t_motion_word want;
            if (awaited.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("%0t: unexpected word state=%0d event=%0d", $time, motion, code);
                return;
            end
            want = awaited.pop_front();
            n_checked++;
            if (motion !== want.motion || code !== want.code) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("%0t: word %0d expected state=%0d event=%0d, got state=%0d event=%0d",
                             $time, n_checked, want.motion, want.code, motion, code);
            end
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic signed [ZW-1:0] i_accel_z   = '0;
    logic [TW-1:0]        i_now_ms    = '0;
    logic                 i_out_stall = 1'b0;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [AW-1:0]        paddr       = '0;
    logic [DW-1:0]        pwdata      = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [SW-1:0]        o_motion_state;
    logic [EW-1:0]        o_event_code;
    logic [DW-1:0]        prdata;
    logic                 pready;

    gesture_scoreboard book;
    bit                no_idle  = 1'b0;
    bit                hold_req = 1'b0;
    logic [TW-1:0]     clock_ms = '0;
    int                step_max = 300;
    int                n_writes = 0;

    jump_squat_gesture_detector dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_accel_z     (i_accel_z),
        .i_now_ms      (i_now_ms),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_motion_state(o_motion_state),
        .o_event_code  (o_event_code),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 i_clk = ~i_clk;

    task automatic send_sample(input logic signed [ZW-1:0] z, input logic [TW-1:0] t);
        int gap;
        bit held;
        gap = 0;
        while (!no_idle && $urandom_range(0, 99) < 30) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_accel_z  <= z;
        i_now_ms   <= t;
        do begin
            @(negedge i_clk);
            held = (o_in_stall !== 1'b0);
            @(posedge i_clk);
        end while (held);
        book.note_sample(z, t);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (book.awaited.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int data);
        bit rdy;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            rdy = (pready === 1'b1);
            @(posedge i_clk);
        end while (!rdy);
        book.set_reg(idx, data[ZW-1:0]);
        n_writes++;
    endtask

    task automatic apply_config(input int js, input int ss, input int jf, input int sr,
                                input int jl, input int se, input int cd, input int at);
        drain();
        write_reg(REG_JUMP_START, js);
        write_reg(REG_SQUAT_START, ss);
        write_reg(REG_JUMP_FALL, jf);
        write_reg(REG_SQUAT_RISE, sr);
        write_reg(REG_JUMP_LAND, jl);
        write_reg(REG_SQUAT_END, se);
        write_reg(REG_COOLDOWN, cd);
        write_reg(REG_ACTION_TIME, at);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic int rnd_level();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic int above_level(int lvl);
        int span;
        if (lvl >= 32767) return 32767;
        span = 32766 - lvl;
        if ($urandom_range(0, 1) && span > 3) span = 3;
        return lvl + 1 + int'($urandom_range(0, span));
    endfunction

    function automatic int below_level(int lvl);
        int span;
        if (lvl <= -32768) return -32768;
        span = lvl + 32767;
        if ($urandom_range(0, 1) && span > 3) span = 3;
        return lvl - 1 - int'($urandom_range(0, span));
    endfunction

    // full-range value, or a threshold itself to hit the strict compares
    function automatic int noise_level();
        case ($urandom_range(0, 11))
            0: return book.jump_start;
            1: return book.squat_start;
            2: return book.jump_fall;
            3: return book.squat_rise;
            4: return book.jump_land;
            5: return book.squat_end;
            default: return rnd_level();
        endcase
    endfunction

    task automatic push_sample(input int z);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            clock_ms = $urandom();
        else if (r < 7)
            clock_ms = clock_ms - $urandom_range(0, step_max);
        else
            clock_ms = clock_ms + $urandom_range(0, step_max);
        send_sample(z[ZW-1:0], clock_ms);
    endtask

    task automatic maybe_noise();
        if ($urandom_range(0, 3) == 0) push_sample(noise_level());
    endtask

    task automatic play_gesture();
        int n;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                push_sample(above_level(book.jump_start));
                maybe_noise();
                push_sample(below_level(book.jump_fall));
                maybe_noise();
                push_sample(below_level(book.jump_land));
            end
            4, 5, 6, 7: begin
                push_sample(below_level(book.squat_start));
                maybe_noise();
                push_sample(above_level(book.squat_rise));
                maybe_noise();
                push_sample(above_level(book.squat_end));
            end
            8: begin
                n = $urandom_range(1, 4);
                repeat (n) push_sample(noise_level());
            end
            default: begin
                if ($urandom_range(0, 1))
                    push_sample(above_level(book.jump_start));
                else
                    push_sample(below_level(book.squat_start));
                n = $urandom_range(1, 3);
                repeat (n) push_sample(noise_level());
            end
        endcase
    endtask

    task automatic random_phase(input int n_words);
        int target;
        target = book.n_samples + n_words;
        while (book.n_samples < target) play_gesture();
    endtask

    initial begin : out_side
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 60;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (no_idle) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < 30);
            end
        end
    end

    initial begin : result_monitor
        logic [SW-1:0] st;
        logic [EW-1:0] ev;
        forever begin
            @(negedge i_clk);
            if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
                st = o_motion_state;
                ev = o_event_code;
                @(posedge i_clk);
                book.check_result(st, ev);
            end
        end
    end

    initial begin : watchdog
        #400000;
        $display("timeout with %0d words outstanding", book.awaited.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        book = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset thresholds: cooldown, both gestures, timeout, wrap, time going back
        send_sample(0, 100);
        send_sample(32767, 701);
        send_sample(20000, 800);
        send_sample(-32768, 900);
        send_sample(-32768, 1000);
        send_sample(-32768, 1601);
        send_sample(20000, 1700);
        send_sample(32767, 1800);
        send_sample(32767, 2501);
        send_sample(30000, 3502);
        send_sample(0, 32'hFFFF_FFFF);
        send_sample(0, 999);
        send_sample(0, 1000);
        send_sample(32767, 500);
        send_sample(-32768, 400);

        // whole gestures on one sample, no restart after an end, no timeout at start
        apply_config(100, -100, 200, -200, 300, -300, 0, 0);
        send_sample(150, 2000);
        send_sample(150, 2000);
        send_sample(-150, 2001);
        send_sample(1000, 2002);
        send_sample(1000, 2003);
        send_sample(-32768, 2003);
        send_sample(-32768, 2004);
        send_sample(-150, 2004);

        apply_config(RST_JUMP_START, RST_SQUAT_START, RST_JUMP_FALL, RST_SQUAT_RISE,
                     RST_JUMP_LAND, RST_SQUAT_END, RST_COOLDOWN, RST_ACTION_TIME);
        clock_ms = 32'hFFFF_F000;
        step_max = 300;
        random_phase(150);

        apply_config(-32768, 32767, 32767, -32768, -32768, 32767, 0, 65535);
        step_max = 20000;
        random_phase(120);

        apply_config(RST_JUMP_START, RST_SQUAT_START, RST_JUMP_FALL, RST_SQUAT_RISE,
                     RST_JUMP_LAND, RST_SQUAT_END, 65535, 0);
        step_max = 40000;
        random_phase(120);

        repeat (2) begin
            apply_config(rnd_level(), rnd_level(), rnd_level(), rnd_level(),
                         rnd_level(), rnd_level(), $urandom_range(0, 500),
                         $urandom_range(0, 400));
            step_max = 300;
            random_phase(150);
        end

        // back-to-back words, then a long output hold-off while input keeps coming
        apply_config(RST_JUMP_START, RST_SQUAT_START, RST_JUMP_FALL, RST_SQUAT_RISE,
                     RST_JUMP_LAND, RST_SQUAT_END, RST_COOLDOWN, RST_ACTION_TIME);
        no_idle = 1'b1;
        random_phase(60);
        hold_req = 1'b1;
        random_phase(60);
        no_idle = 1'b0;
        drain();
        random_phase(40);

        drain();
        repeat (10) @(posedge i_clk);
        $display("run covered %0d samples, %0d words checked, %0d register writes, %0d errors",
                 book.n_samples, book.n_checked, n_writes, book.n_bad);
        $display("events: %0d jump begin, %0d squat begin, %0d jump end, %0d squat end, %0d %s",
                 book.n_event[EV_JUMP_BEGIN], book.n_event[EV_SQUAT_BEGIN],
                 book.n_event[EV_JUMP_END], book.n_event[EV_SQUAT_END],
                 book.n_event[EV_TIMEOUT], "timeout");
        if (book.n_bad == 0 && book.awaited.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/jsgd_pkg.sv
sv/jsgd_cfg_regs.sv
sv/jsgd_step_logic.sv
sv/jump_squat_gesture_detector.sv
sim/tb.sv
